### hw/rtl/mgs_pkg.sv
// Shared types and constants for the median gradient sharpness block.
package mgs_pkg;

  localparam int PORT_PIX_W = 16;   // pixel field width on the stream
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int DIM_W      = 13;   // frame dimension registers
  localparam int CNT_W      = 12;   // column / row counters, crop registers
  localparam int POS_W      = 14;   // crop bound sums
  localparam int SUM_W      = 64;
  localparam int OUT_DEPTH  = 8;    // result FIFO entries
  localparam int OUT_PTR_W  = 3;
  localparam int PEND_W     = 4;    // counts 0..OUT_DEPTH

  localparam logic [DIM_W-1:0] DIM_MAX = 13'd4096;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_X       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_Y       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NARROW       = 3'd6;

  // per-pixel control that rides along the pipeline
  typedef struct packed {
    logic clr;     // frame start: clear the sum before this pixel
    logic med_en;  // a median is produced at this pixel
    logic krn_en;  // the kernel response is accumulated
    logic last;    // last pixel of the frame: emit the score
  } tag_t;

endpackage

### hw/rtl/mgs_raw_median.sv
// Raw two-row line store and pipelined 3x3 median.
module mgs_raw_median #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_go,
  input  logic [PIXEL_BITS-1:0]        in_pix,
  input  logic [$clog2(MAX_WIDTH)-1:0] in_col,
  input  logic                         in_par,
  input  logic [$clog2(MAX_WIDTH)-1:0] in_mcol,
  input  logic                         in_mpar,
  input  mgs_pkg::tag_t                in_tag,
  output logic                         out_vld,
  output mgs_pkg::tag_t                out_tag,
  output logic [$clog2(MAX_WIDTH)-1:0] out_mcol,
  output logic                         out_mpar,
  output logic [PIXEL_BITS-1:0]        out_med
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int PB = PIXEL_BITS;
  localparam int EW = 2 * PB;

  function automatic logic [PB-1:0] mx(input logic [PB-1:0] a, input logic [PB-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [PB-1:0] mn(input logic [PB-1:0] a, input logic [PB-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PB-1:0] med3(input logic [PB-1:0] a, input logic [PB-1:0] b,
                                         input logic [PB-1:0] c);
    return mx(mn(a, b), mn(mx(a, b), c));
  endfunction

  // entry holds both rows of a column: low half parity 0, high half parity 1
  logic [EW-1:0] mem [MAX_WIDTH];
  logic [EW-1:0] q_r;
  logic          fwd_r;
  logic [EW-1:0] fwd_dat_r;

  logic          s1_vld_r;
  logic [PB-1:0] s1_pix_r;
  logic [AW-1:0] s1_col_r;
  logic          s1_par_r;
  logic [AW-1:0] s1_mcol_r;
  logic          s1_mpar_r;
  mgs_pkg::tag_t s1_tag_r;

  logic [EW-1:0] ent;
  logic [EW-1:0] ent_new;
  logic [PB-1:0] top_px;
  logic [PB-1:0] mid_px;
  logic [PB-1:0] lo1, hi1, x1, n_lo, n_mi, n_hi;

  // sorted columns of the raw window, index 2 newest
  logic [2:0][PB-1:0] lo_r, mi_r, hi_r;

  logic          s2_vld_r;
  mgs_pkg::tag_t s2_tag_r;
  logic [AW-1:0] s2_mcol_r;
  logic          s2_mpar_r;

  logic          s3_vld_r;
  mgs_pkg::tag_t s3_tag_r;
  logic [AW-1:0] s3_mcol_r;
  logic          s3_mpar_r;
  logic [PB-1:0] s3_a_r, s3_b_r, s3_c_r;

  // read issue; forward when stage 1 writes the same column this cycle
  always_ff @(posedge clk) begin
    if (in_go) begin
      q_r       <= mem[in_col];
      fwd_r     <= s1_vld_r && (s1_col_r == in_col);
      fwd_dat_r <= ent_new;
      s1_pix_r  <= in_pix;
      s1_col_r  <= in_col;
      s1_par_r  <= in_par;
      s1_mcol_r <= in_mcol;
      s1_mpar_r <= in_mpar;
      s1_tag_r  <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      mem[s1_col_r] <= ent_new;
    end
  end

  always_comb begin
    ent     = fwd_r ? fwd_dat_r : q_r;
    top_px  = s1_par_r ? ent[EW-1:PB] : ent[PB-1:0];
    mid_px  = s1_par_r ? ent[PB-1:0] : ent[EW-1:PB];
    ent_new = s1_par_r ? {s1_pix_r, ent[PB-1:0]} : {ent[EW-1:PB], s1_pix_r};
    lo1     = mn(top_px, mid_px);
    hi1     = mx(top_px, mid_px);
    x1      = mx(lo1, s1_pix_r);
    n_lo    = mn(lo1, s1_pix_r);
    n_mi    = mn(hi1, x1);
    n_hi    = mx(hi1, x1);
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      lo_r <= {n_lo, lo_r[2], lo_r[1]};
      mi_r <= {n_mi, mi_r[2], mi_r[1]};
      hi_r <= {n_hi, hi_r[2], hi_r[1]};
    end
    s2_tag_r  <= s1_tag_r;
    s2_mcol_r <= s1_mcol_r;
    s2_mpar_r <= s1_mpar_r;
    // max of lows, median of middles, min of highs
    s3_a_r    <= mx(mx(lo_r[0], lo_r[1]), lo_r[2]);
    s3_b_r    <= med3(mi_r[0], mi_r[1], mi_r[2]);
    s3_c_r    <= mn(mn(hi_r[0], hi_r[1]), hi_r[2]);
    s3_tag_r  <= s2_tag_r;
    s3_mcol_r <= s2_mcol_r;
    s3_mpar_r <= s2_mpar_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_go;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  assign out_vld  = s3_vld_r;
  assign out_tag  = s3_tag_r;
  assign out_mcol = s3_mcol_r;
  assign out_mpar = s3_mpar_r;
  assign out_med  = med3(s3_a_r, s3_b_r, s3_c_r);

endmodule

### hw/rtl/mgs_edge_energy.sv
// Median line store, diagonal kernel, square and saturating accumulator.
module mgs_edge_energy #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  mgs_pkg::tag_t                in_tag,
  input  logic [$clog2(MAX_WIDTH)-1:0] in_mcol,
  input  logic                         in_mpar,
  input  logic [PIXEL_BITS-1:0]        in_med,
  output logic                         res_vld,
  output logic [mgs_pkg::SUM_W-1:0]    res_sum,
  output logic                         res_clip
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int PB = PIXEL_BITS;
  localparam int EW = 2 * PB;
  localparam int RW = PB + 3;        // signed kernel response
  localparam int MW = PB + 2;        // response magnitude
  localparam int QW = 2 * MW;        // squared response
  localparam int SW = mgs_pkg::SUM_W;

  logic [EW-1:0] mem [MAX_WIDTH];
  logic [EW-1:0] q_r;
  logic          fwd_r;
  logic [EW-1:0] fwd_dat_r;

  logic          s4_vld_r;
  mgs_pkg::tag_t s4_tag_r;
  logic [AW-1:0] s4_mcol_r;
  logic          s4_mpar_r;
  logic [PB-1:0] s4_med_r;

  logic          wr;
  logic [EW-1:0] ent, ent_new;
  logic [PB-1:0] mt, mm;
  logic [RW-1:0] resp;

  // median window: newest column full, previous column top and middle
  logic [PB-1:0] c2t_r, c2m_r, c2b_r, c1t_r, c1m_r;

  logic          s5_vld_r;
  mgs_pkg::tag_t s5_tag_r;
  logic [RW-1:0] s5_resp_r;
  logic [RW-1:0] neg;
  logic [MW-1:0] mag;

  logic          s6_vld_r;
  mgs_pkg::tag_t s6_tag_r;
  logic [QW-1:0] s6_sq_r;

  logic [SW-1:0] sum_r;
  logic          clip_r;
  logic [SW-1:0] base, sum_new;
  logic          base_clip, clip_new;
  logic [SW:0]   add;

  always_ff @(posedge clk) begin
    if (in_vld && in_tag.med_en) begin
      q_r       <= mem[in_mcol];
      fwd_r     <= wr && (s4_mcol_r == in_mcol);
      fwd_dat_r <= ent_new;
    end
    s4_tag_r  <= in_tag;
    s4_mcol_r <= in_mcol;
    s4_mpar_r <= in_mpar;
    s4_med_r  <= in_med;
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[s4_mcol_r] <= ent_new;
    end
  end

  always_comb begin
    wr      = s4_vld_r && s4_tag_r.med_en;
    ent     = fwd_r ? fwd_dat_r : q_r;
    mt      = s4_mpar_r ? ent[EW-1:PB] : ent[PB-1:0];
    mm      = s4_mpar_r ? ent[PB-1:0] : ent[EW-1:PB];
    ent_new = s4_mpar_r ? {s4_med_r, ent[PB-1:0]} : {ent[EW-1:PB], s4_med_r};
    // [-2 -1 0; -1 0 1; 0 1 2] over the window after this shift
    resp    = RW'(mm) + RW'(c2b_r) + (RW'(s4_med_r) << 1)
            - (RW'(c1t_r) << 1) - RW'(c2t_r) - RW'(c1m_r);
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      c1t_r <= c2t_r;
      c1m_r <= c2m_r;
      c2t_r <= mt;
      c2m_r <= mm;
      c2b_r <= s4_med_r;
    end
    s5_tag_r  <= s4_tag_r;
    s5_resp_r <= resp;
    s6_tag_r  <= s5_tag_r;
    s6_sq_r   <= QW'(mag) * QW'(mag);
  end

  always_comb begin
    neg = -s5_resp_r;
    mag = s5_resp_r[RW-1] ? neg[MW-1:0] : s5_resp_r[MW-1:0];
  end

  always_comb begin
    base      = s6_tag_r.clr ? '0 : sum_r;
    base_clip = s6_tag_r.clr ? 1'b0 : clip_r;
    add       = {1'b0, base} + (SW + 1)'(s6_sq_r);
    sum_new   = base;
    clip_new  = base_clip;
    if (s6_tag_r.krn_en) begin
      if (add[SW]) begin
        sum_new  = '1;
        clip_new = 1'b1;
      end else begin
        sum_new  = add[SW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      sum_r    <= '0;
      clip_r   <= 1'b0;
    end else begin
      s4_vld_r <= in_vld;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
      if (s6_vld_r) begin
        if (s6_tag_r.last) begin
          sum_r  <= '0;
          clip_r <= 1'b0;
        end else begin
          sum_r  <= sum_new;
          clip_r <= clip_new;
        end
      end
    end
  end

  assign res_vld  = s6_vld_r && s6_tag_r.last;
  assign res_sum  = sum_new;
  assign res_clip = clip_new;

endmodule

### hw/rtl/median_gradient_sharpness.sv
// Top level: config, frame counters, line-store pipeline and result FIFO.
//
// Channel | Dir | Handshake           | Payload
// in_     | in  | in_tvalid/in_tready | tdata: pixel[15:0]; tuser: frame_start
// out_    | out | out_tvalid/tready   | tdata: sharpness[63:0]; tuser: saturated
// cfg_    | in  | cfg_valid/cfg_ready | cfg_index[2:0], cfg_data[12:0]
//
// One pixel per cycle sustained while in_tready is high. A pixel reads its
// column of the raw line store on acceptance; the median leaves the
// three-stage sorter and does a read-modify-write of the median line store;
// kernel, square and the 64-bit accumulate follow, and the frame's score is
// then written to the output FIFO. in_tready drops only while 8 scores are
// outstanding (in flight or waiting in the FIFO). cfg_ready is always high.
// Reset (rst_n low, synchronous) restores register defaults and clears the
// counters, the sum and the FIFO; line stores need no clearing pass.
module median_gradient_sharpness #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mgs_pkg::PORT_PIX_W-1:0]    in_tdata,   // [15:0] pixel
  input  logic                              in_tuser,   // [0] frame_start
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mgs_pkg::SUM_W-1:0]         out_tdata,  // [63:0] sharpness
  output logic                              out_tuser,  // [0] saturated
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mgs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mgs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int PB = PIXEL_BITS;
  localparam int DW = mgs_pkg::DIM_W;
  localparam int CW = mgs_pkg::CNT_W;
  localparam int PW = mgs_pkg::POS_W;
  localparam int SW = mgs_pkg::SUM_W;
  localparam int QP = mgs_pkg::OUT_PTR_W;
  localparam int NW = mgs_pkg::PEND_W;

  // configuration registers
  logic [DW-1:0] frame_width_r, frame_height_r;
  logic [CW-1:0] crop_x_r, crop_y_r, crop_width_r, crop_height_r;
  logic          narrow_r;

  // frame position
  logic [CW-1:0] col_cnt_r, row_cnt_r;
  logic [AW-1:0] colw_r;     // column modulo the line store depth

  logic          acc;
  logic          fs;
  logic [CW-1:0] c, r;
  logic [AW-1:0] cw, mcol;
  logic [DW-1:0] fw, fh;
  logic          lc, lr;
  logic [PW-1:0] cx, cy, xl, yl, xh, yh, xk, yk;
  mgs_pkg::tag_t tag;
  logic [PB-1:0] pix;

  // pipeline links
  logic          m_vld;
  mgs_pkg::tag_t m_tag;
  logic [AW-1:0] m_mcol;
  logic          m_mpar;
  logic [PB-1:0] m_med;
  logic          res_vld;
  logic [SW-1:0] res_sum;
  logic          res_clip;

  // result FIFO
  logic [SW-1:0] fifo_sum_r  [mgs_pkg::OUT_DEPTH];
  logic          fifo_clip_r [mgs_pkg::OUT_DEPTH];
  logic [QP-1:0] wp_r, rp_r;
  logic [NW-1:0] fifo_cnt_r, pend_r;
  logic          out_hs;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 13'd640;
      frame_height_r <= 13'd480;
      crop_x_r       <= 12'd256;
      crop_y_r       <= 12'd192;
      crop_width_r   <= 12'd128;
      crop_height_r  <= 12'd96;
      narrow_r       <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mgs_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        mgs_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        mgs_pkg::REG_CROP_X:       crop_x_r       <= cfg_data[CW-1:0];
        mgs_pkg::REG_CROP_Y:       crop_y_r       <= cfg_data[CW-1:0];
        mgs_pkg::REG_CROP_WIDTH:   crop_width_r   <= cfg_data[CW-1:0];
        mgs_pkg::REG_CROP_HEIGHT:  crop_height_r  <= cfg_data[CW-1:0];
        mgs_pkg::REG_NARROW:       narrow_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign acc = in_tvalid && in_tready;

  always_comb begin
    fs  = in_tuser;
    c   = fs ? '0 : col_cnt_r;
    r   = fs ? '0 : row_cnt_r;
    cw  = fs ? '0 : colw_r;
    // dimensions clamp to 1..4096
    fw  = (frame_width_r == '0) ? DW'(1)
        : ((frame_width_r > mgs_pkg::DIM_MAX) ? mgs_pkg::DIM_MAX : frame_width_r);
    fh  = (frame_height_r == '0) ? DW'(1)
        : ((frame_height_r > mgs_pkg::DIM_MAX) ? mgs_pkg::DIM_MAX : frame_height_r);
    lc  = ({1'b0, c} + DW'(1)) >= fw;
    lr  = ({1'b0, r} + DW'(1)) >= fh;
    cx  = PW'(c);
    cy  = PW'(r);
    // median center (c-1, r-1) inside the crop, kernel fully inside it
    xl  = PW'(crop_x_r) + PW'(1);
    yl  = PW'(crop_y_r) + PW'(1);
    xh  = PW'(crop_x_r) + PW'(crop_width_r) + PW'(1);
    yh  = PW'(crop_y_r) + PW'(crop_height_r) + PW'(1);
    xk  = PW'(crop_x_r) + PW'(3);
    yk  = PW'(crop_y_r) + PW'(3);
    tag.clr    = fs;
    tag.med_en = (c >= CW'(2)) && (r >= CW'(2)) && (cx >= xl) && (cx < xh)
              && (cy >= yl) && (cy < yh);
    tag.krn_en = tag.med_en && (c >= CW'(4)) && (r >= CW'(4)) && (cx >= xk) && (cy >= yk);
    tag.last   = lc && lr;
    mcol = (cw == '0) ? AW'(MAX_WIDTH - 1) : cw - AW'(1);
    pix  = in_tdata[PB-1:0] & (narrow_r ? PB'(8'hFF) : {PB{1'b1}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      colw_r    <= '0;
    end else if (acc) begin
      if (lc) begin
        col_cnt_r <= '0;
        colw_r    <= '0;
        row_cnt_r <= lr ? '0 : r + CW'(1);
      end else begin
        col_cnt_r <= c + CW'(1);
        colw_r    <= (cw == AW'(MAX_WIDTH - 1)) ? '0 : cw + AW'(1);
        row_cnt_r <= r;
      end
    end
  end

  mgs_raw_median #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_raw (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_go    (acc),
    .in_pix   (pix),
    .in_col   (cw),
    .in_par   (r[0]),
    .in_mcol  (mcol),
    .in_mpar  (~r[0]),
    .in_tag   (tag),
    .out_vld  (m_vld),
    .out_tag  (m_tag),
    .out_mcol (m_mcol),
    .out_mpar (m_mpar),
    .out_med  (m_med)
  );

  mgs_edge_energy #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_edge (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (m_vld),
    .in_tag   (m_tag),
    .in_mcol  (m_mcol),
    .in_mpar  (m_mpar),
    .in_med   (m_med),
    .res_vld  (res_vld),
    .res_sum  (res_sum),
    .res_clip (res_clip)
  );

  // credits: every accepted last pixel owns a FIFO slot until its score leaves
  assign out_hs     = out_tvalid && out_tready;
  assign in_tready  = pend_r < NW'(mgs_pkg::OUT_DEPTH);
  assign out_tvalid = fifo_cnt_r != '0;
  assign out_tdata  = fifo_sum_r[rp_r];
  assign out_tuser  = fifo_clip_r[rp_r];

  always_ff @(posedge clk) begin
    if (res_vld) begin
      fifo_sum_r[wp_r]  <= res_sum;
      fifo_clip_r[wp_r] <= res_clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      rp_r       <= '0;
      fifo_cnt_r <= '0;
      pend_r     <= '0;
    end else begin
      if (res_vld) wp_r <= wp_r + QP'(1);
      if (out_hs)  rp_r <= rp_r + QP'(1);
      fifo_cnt_r <= fifo_cnt_r + NW'(res_vld) - NW'(out_hs);
      pend_r     <= pend_r + NW'(acc && tag.last) - NW'(out_hs);
    end
  end

  // FIFO never holds more than the outstanding credits
  a_fifo_le_pend: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= pend_r)
    else $error("result FIFO holds more than outstanding credits");

  // a score arrives only with room in the FIFO
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> (fifo_cnt_r != NW'(mgs_pkg::OUT_DEPTH)))
    else $error("result FIFO overflow");

  // an accepted last pixel of a frame is always followed by its score
  a_last_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && tag.last) |-> ##6 res_vld)
    else $error("score not produced on schedule");

endmodule
